// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property check, disabled in reset
`define AHT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same check, also active during reset
`define AHT_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/aht_pkg.sv =====
// ----------------------------------------------------------------------------
// aht_pkg
// Types and constants for the aging hash table tracker.
// ----------------------------------------------------------------------------
package aht_pkg;

  localparam int unsigned TableSize = 1024;
  localparam int unsigned KeyBytes  = 8;
  localparam int unsigned IdxW      = $clog2(TableSize);
  localparam int unsigned CntW      = 11;
  localparam int unsigned TsW       = 63;
  localparam int unsigned KeyW      = 8 * KeyBytes;
  localparam logic [TsW-1:0] MaxAgeReset = 63'd300000000;
  localparam logic signed [7:0] RssiHighReset = -8'sd127;

  localparam logic CmdObserve = 1'b0;
  localparam logic CmdSweep   = 1'b1;

  typedef struct packed {
    logic                command;
    logic [63:0]         fingerprint;
    logic [TsW-1:0]      timestamp;
    logic signed [7:0]   rssi;
  } aht_in_t;

  typedef struct packed {
    logic                fresh;
    logic [CntW-1:0]     swept_count;
    logic [CntW-1:0]     live_devices;
    logic [31:0]         obs_total;
    logic [31:0]         evicted_total;
    logic signed [7:0]   rssi_low;
    logic signed [7:0]   rssi_high;
  } aht_out_t;

  // one memory word: used flag, key, last-seen time
  typedef struct packed {
    logic            used;
    logic [KeyW-1:0] key;
    logic [TsW-1:0]  seen;
  } aht_slot_t;

endpackage

// ===== rtl/aht_ram.sv =====
// ----------------------------------------------------------------------------
// aht_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module aht_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/aging_hash_table_tracker.sv =====
// ----------------------------------------------------------------------------
// aging_hash_table_tracker
// Open-addressed fingerprint table with linear probing, oldest-entry eviction
// and aged-entry sweeps; reports running statistics per command.
// ----------------------------------------------------------------------------
// channel  | direction | handshake          | payload
// command  | in        | start & !busy      | in_i   (aht_in_t)
// result   | out       | done_o strobe      | out_o  (aht_out_t)
// max_age  | in        | cfg_valid_i & cfg_ready_o | cfg_data_i
//
// After reset a clearing pass walks all 1024 slots (busy high).
// Observe: probed slots are read one at a time; a full-table miss adds a scan
// of all 1024 slots for the oldest entry. Sweep reads all 1024 slots. Both are
// set by the one read port of the slot memory. One command at a time; done_o
// pulses for one cycle and cannot be stalled. max_age is written only while idle.
module aging_hash_table_tracker
  import aht_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  aht_in_t         in_i,
  output logic            done_o,
  output aht_out_t        out_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [TsW-1:0]  cfg_data_i
);
`include "assert_macros.svh"

  localparam logic [2:0] StClear = 3'd0;
  localparam logic [2:0] StIdle  = 3'd1;
  localparam logic [2:0] StProbe = 3'd2;
  localparam logic [2:0] StOld   = 3'd3;
  localparam logic [2:0] StSweep = 3'd4;
  localparam logic [2:0] StDone  = 3'd5;

  logic [2:0]       st_q, st_d;
  logic [IdxW:0]    cnt_q, cnt_d;     // slots issued
  logic [IdxW:0]    rcv_q, rcv_d;     // slots whose data has returned
  logic [IdxW-1:0]  raddr_q, raddr_d;
  logic             rvld_q;
  logic [IdxW-1:0]  ridx_q;
  aht_in_t          cmd_q;
  logic [TsW-1:0]   max_age_q;
  logic [IdxW-1:0]  best_idx_q, best_idx_d;
  logic [TsW-1:0]   best_ts_q, best_ts_d;
  logic [CntW-1:0]  live_q, live_d, swept_q, swept_d;
  logic [31:0]      obs_q, obs_d, evc_q, evc_d;
  logic signed [7:0] rmin_q, rmin_d, rmax_q, rmax_d;
  logic             fresh_q, fresh_d;
  logic             we;
  logic [IdxW-1:0]  waddr;
  aht_slot_t        wdata, rdata;
  logic [IdxW-1:0]  home;
  logic [TsW-1:0]   age;
  logic             stale;
  logic             rd_en;

  assign home = cmd_q.fingerprint[IdxW-1:0];
  assign age  = cmd_q.timestamp - rdata.seen;
  assign stale = rdata.used && (cmd_q.timestamp > rdata.seen) && (age > max_age_q);

  // the address presented at an edge is the one held in raddr_q after it
  aht_ram #(.Width($bits(aht_slot_t)), .Depth(TableSize)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr_d),
    .rdata_o(rdata)
  );

  assign busy        = (st_q != StIdle);
  assign cfg_ready_o = (st_q == StIdle);

  always_comb begin
    st_d = st_q; cnt_d = cnt_q; rcv_d = rcv_q; raddr_d = raddr_q;
    best_idx_d = best_idx_q; best_ts_d = best_ts_q;
    live_d = live_q; swept_d = swept_q; obs_d = obs_q; evc_d = evc_q;
    rmin_d = rmin_q; rmax_d = rmax_q; fresh_d = fresh_q;
    we = 1'b0; waddr = ridx_q; wdata = '0; rd_en = 1'b0;
    unique case (st_q)
      StClear: begin
        we = 1'b1;
        waddr = cnt_q[IdxW-1:0];
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == (IdxW+1)'(TableSize - 1)) st_d = StIdle;
      end
      StIdle: begin
        cnt_d = '0; rcv_d = '0; fresh_d = 1'b0; swept_d = '0;
        if (start) begin
          raddr_d = (in_i.command == CmdSweep) ? '0 : in_i.fingerprint[IdxW-1:0];
          cnt_d = (IdxW+1)'(1);
          st_d = (in_i.command == CmdSweep) ? StSweep : StProbe;
        end
      end
      StProbe: begin
        // one slot in flight at a time; decide on return
        if (rvld_q) begin
          if (!rdata.used || rdata.key == cmd_q.fingerprint[KeyW-1:0]) begin
            we = 1'b1;
            wdata.used = 1'b1;
            wdata.key = cmd_q.fingerprint[KeyW-1:0];
            wdata.seen = cmd_q.timestamp;
            if (!rdata.used) begin
              live_d = live_q + 1'b1;
              fresh_d = 1'b1;
            end
            obs_d = obs_q + 1'b1;
            if (cmd_q.rssi > rmax_q) rmax_d = cmd_q.rssi;
            if (cmd_q.rssi < rmin_q) rmin_d = cmd_q.rssi;
            st_d = StDone;
          end else if (cnt_q == (IdxW+1)'(TableSize)) begin
            // full table: rescan from home for the oldest entry
            raddr_d = home;
            cnt_d = (IdxW+1)'(1);
            rcv_d = '0;
            st_d = StOld;
          end else begin
            raddr_d = raddr_q + 1'b1;
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      StOld: begin
        if (cnt_q != (IdxW+1)'(TableSize)) begin
          raddr_d = raddr_q + 1'b1;
          cnt_d = cnt_q + 1'b1;
        end
        if (rvld_q) begin
          rcv_d = rcv_q + 1'b1;
          if (rcv_q == '0 || rdata.seen < best_ts_q) begin
            best_ts_d = rdata.seen;
            best_idx_d = ridx_q;
          end
          if (rcv_q == (IdxW+1)'(TableSize - 1)) begin
            we = 1'b1;
            waddr = (rcv_q == '0 || rdata.seen < best_ts_q) ? ridx_q : best_idx_q;
            wdata.used = 1'b1;
            wdata.key = cmd_q.fingerprint[KeyW-1:0];
            wdata.seen = cmd_q.timestamp;
            evc_d = evc_q + 1'b1;
            fresh_d = 1'b1;
            obs_d = obs_q + 1'b1;
            if (cmd_q.rssi > rmax_q) rmax_d = cmd_q.rssi;
            if (cmd_q.rssi < rmin_q) rmin_d = cmd_q.rssi;
            st_d = StDone;
          end
        end
      end
      StSweep: begin
        if (cnt_q != (IdxW+1)'(TableSize)) begin
          raddr_d = raddr_q + 1'b1;
          cnt_d = cnt_q + 1'b1;
        end
        if (rvld_q) begin
          rcv_d = rcv_q + 1'b1;
          if (stale) begin
            // drop the aged entry; only the used flag matters
            we = 1'b1;
            wdata = rdata;
            wdata.used = 1'b0;
            live_d = live_q - 1'b1;
            swept_d = swept_q + 1'b1;
            evc_d = evc_q + 1'b1;
          end
          if (rcv_q == (IdxW+1)'(TableSize - 1)) st_d = StDone;
        end
      end
      StDone: st_d = StIdle;
      default: st_d = StIdle;
    endcase
    rd_en = (st_q == StIdle && start) || (raddr_d != raddr_q) || (cnt_d != cnt_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StClear; cnt_q <= '0; rcv_q <= '0; raddr_q <= '0;
      rvld_q <= 1'b0; ridx_q <= '0;
      max_age_q <= MaxAgeReset;
      live_q <= '0; swept_q <= '0; obs_q <= '0; evc_q <= '0;
      rmin_q <= '0; rmax_q <= RssiHighReset; fresh_q <= 1'b0;
      best_idx_q <= '0; best_ts_q <= '0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; rcv_q <= rcv_d; raddr_q <= raddr_d;
      // read issued this cycle returns next cycle
      rvld_q <= rd_en && (st_q != StClear);
      ridx_q <= raddr_d;
      live_q <= live_d; swept_q <= swept_d; obs_q <= obs_d; evc_q <= evc_d;
      rmin_q <= rmin_d; rmax_q <= rmax_d; fresh_q <= fresh_d;
      best_idx_q <= best_idx_d; best_ts_q <= best_ts_d;
      if (cfg_valid_i && cfg_ready_o) max_age_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == StIdle && start) cmd_q <= in_i;
  end

  assign done_o = (st_q == StDone);
  always_comb begin
    out_o.fresh = fresh_q;
    out_o.swept_count = swept_q;
    out_o.live_devices = live_q;
    out_o.obs_total = obs_q;
    out_o.evicted_total = evc_q;
    out_o.rssi_low = rmin_q;
    out_o.rssi_high = rmax_q;
  end

  `AHT_ASSERT(a_done_pulse, clk_i, rst_ni, done_o |=> !done_o, "done longer than one cycle")
  `AHT_ASSERT(a_live_range, clk_i, rst_ni, live_q <= CntW'(TableSize), "live count overflow")
  `AHT_ASSERT(a_sweep_no_fresh, clk_i, rst_ni,
              (done_o && cmd_q.command == CmdSweep) |-> !fresh_q, "sweep reported fresh")
  `AHT_ASSERT(a_obs_step, clk_i, rst_ni,
              (done_o && cmd_q.command == CmdObserve) |-> (obs_q != $past(obs_q)),
              "observe did not count")

endmodule
